/* hw/rtl/cgsm_pkg.sv */
// shared types and constants for the color gradient stop map
`timescale 1ns / 1ps
package cgsm_pkg;

    localparam int MaxStops = 16;
    localparam int PosW = 17;
    localparam int ChW = 16;
    localparam int ColW = 64;
    localparam logic [PosW-1:0] OneQ16 = 17'd65536;

    typedef enum logic [2:0] {
        FN_LOOKUP = 3'd0,
        FN_INSERT = 3'd1,
        FN_SET_FIRST = 3'd2,
        FN_SET_LAST = 3'd3,
        FN_READ = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BADPOS = 3'd1,
        ST_FULL = 3'd2,
        ST_FEW = 3'd3,
        ST_EMPTY = 3'd4,
        ST_BADIDX = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_RDCOL,
        S_BLEND_RD,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word
        logic scan_rst;  // zero the scan index
        logic scan_inc;
        logic shift;     // move entry idx-1 to idx, step idx down
        logic wr_new;    // write new stop at idx
        logic wr_color;  // write color at recolor index
        logic cnt_inc;
        logic rd_lo;     // latch color of stop lo
        logic rd_hi;
        logic mul;       // form the numerators
        logic div_start;
        logic set_status;
        status_t status;
        logic clr_color;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic t_bad;
        logic full;
        logic empty;
        logic few;
        logic idx_bad;
        logic scan_end;  // scan reached count
        logic scan_hit;  // pos at scan index above key
        logic at_ins;    // shift index reached insert point
        logic div_done;  // divider finished or not in use
    } stat_t;

endpackage

/* hw/rtl/color_gradient_stop_map_top.sv */
// top level of the color gradient stop map
// channel | dir | tdata (low bit up)                                      | tuser
// s_      | in  | lookup_t 18, stop_pos 17, stop_index 4, r,g,b,a 16 each | func 3
// m_      | out | red,green,blue,alpha 16 each, count_out 5             | status 3
// one word at a time; insert and lookup scan the stop table one entry at a time,
// and a lookup that blends two stops then runs a bit-serial divider
// aresetn clears the stop count; table contents are kept until written
// a result waits in its output register while m_tready is low
`timescale 1ns / 1ps
module color_gradient_stop_map_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // lookup_t, stop_pos, stop_index, red, green, blue, alpha
    input  logic [2:0]   s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // red_out, green_out, blue_out, alpha_out, count_out
    output logic [2:0]   m_tuser   // status
);
    cgsm_pkg::cmd_t  cmd;
    cgsm_pkg::stat_t st;
    logic busy, done, in_fire, out_free;
    logic [2:0]  status_w;
    logic [63:0] color_w;
    logic [4:0]  count_w;
    logic        mvalid_reg;
    logic [71:0] mdata_reg;
    logic [2:0]  muser_reg;

    assign s_tready = !busy;
    assign in_fire = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    cgsm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .st(st), .cmd(cmd), .busy(busy), .done(done)
    );

    cgsm_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .func_i(s_tuser),
        .lookup_t_i(s_tdata[17:0]),
        .stop_pos_i(s_tdata[34:18]),
        .stop_index_i(s_tdata[38:35]),
        .color_i({s_tdata[102:87], s_tdata[86:71], s_tdata[70:55], s_tdata[54:39]}),
        .st(st), .status_o(status_w), .color_o(color_w), .count_o(count_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (done) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            mdata_reg <= {3'b0, count_w, color_w};
            muser_reg <= status_w;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;
    assign m_tuser = muser_reg;

    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> busy) else $error("accepted word did not start a job");
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> out_free) else $error("result overwrote a waiting word");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_w <= 5'(cgsm_pkg::MaxStops)) else $error("stop count above table size");
endmodule

/* hw/rtl/cgsm_ctrl.sv */
// controller state machine for the color gradient stop map
`timescale 1ns / 1ps
module cgsm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              out_free,
    input  cgsm_pkg::stat_t   st,
    output cgsm_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);
    cgsm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cgsm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.status = cgsm_pkg::ST_OK;
        busy = (state_reg != cgsm_pkg::S_IDLE);
        done = 1'b0;
        case (state_reg)
            cgsm_pkg::S_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = cgsm_pkg::S_DECODE;
                end
            end
            cgsm_pkg::S_DECODE: begin
                cmd.scan_rst = 1'b1;
                cmd.set_status = 1'b1;
                cmd.clr_color = 1'b1;
                state_next = cgsm_pkg::S_DONE;
                case (st.func)
                    cgsm_pkg::FN_LOOKUP: begin
                        if (st.few) begin
                            cmd.status = cgsm_pkg::ST_FEW;
                        end else begin
                            state_next = cgsm_pkg::S_SCAN;
                        end
                    end
                    cgsm_pkg::FN_INSERT: begin
                        if (st.t_bad) begin
                            cmd.status = cgsm_pkg::ST_BADPOS;
                        end else if (st.full) begin
                            cmd.status = cgsm_pkg::ST_FULL;
                        end else begin
                            state_next = cgsm_pkg::S_SCAN;
                        end
                    end
                    cgsm_pkg::FN_SET_FIRST, cgsm_pkg::FN_SET_LAST: begin
                        if (st.empty) begin
                            cmd.status = cgsm_pkg::ST_EMPTY;
                        end else begin
                            state_next = cgsm_pkg::S_WRITE;
                        end
                    end
                    cgsm_pkg::FN_READ: begin
                        if (st.idx_bad) begin
                            cmd.status = cgsm_pkg::ST_BADIDX;
                        end else begin
                            state_next = cgsm_pkg::S_RDCOL;
                        end
                    end
                    default: ;
                endcase
            end
            cgsm_pkg::S_SCAN: begin
                // insert runs to the count, lookup stops at the first stop above t
                if (st.scan_end || (st.scan_hit && st.func != cgsm_pkg::FN_INSERT)) begin
                    if (st.func == cgsm_pkg::FN_INSERT) begin
                        state_next = cgsm_pkg::S_SHIFT;
                    end else begin
                        state_next = cgsm_pkg::S_BLEND_RD;
                    end
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            cgsm_pkg::S_SHIFT: begin
                if (st.at_ins) begin
                    cmd.wr_new = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next = cgsm_pkg::S_DONE;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            cgsm_pkg::S_WRITE: begin
                cmd.wr_color = 1'b1;
                state_next = cgsm_pkg::S_DONE;
            end
            cgsm_pkg::S_RDCOL: begin
                cmd.rd_lo = 1'b1;
                state_next = cgsm_pkg::S_DONE;
            end
            cgsm_pkg::S_BLEND_RD: begin
                cmd.rd_lo = 1'b1;
                cmd.rd_hi = 1'b1;
                state_next = cgsm_pkg::S_MUL;
            end
            cgsm_pkg::S_MUL: begin
                cmd.mul = 1'b1;
                state_next = cgsm_pkg::S_DIV;
            end
            cgsm_pkg::S_DIV: begin
                if (st.div_done) begin
                    state_next = cgsm_pkg::S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                end
            end
            cgsm_pkg::S_DONE: begin
                if (out_free) begin
                    done = 1'b1;
                    state_next = cgsm_pkg::S_IDLE;
                end
            end
            default: state_next = cgsm_pkg::S_IDLE;
        endcase
    end
endmodule

/* hw/rtl/cgsm_dpath.sv */
// datapath for the color gradient stop map: stop tables, scan, blend and divider
`timescale 1ns / 1ps
module cgsm_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cgsm_pkg::cmd_t        cmd,
    input  logic [2:0]            func_i,
    input  logic signed [17:0]    lookup_t_i,
    input  logic [16:0]           stop_pos_i,
    input  logic [3:0]            stop_index_i,
    input  logic [63:0]           color_i,
    output cgsm_pkg::stat_t       st,
    output logic [2:0]            status_o,
    output logic [63:0]           color_o,
    output logic [4:0]            count_o
);
    localparam int MAX_STOPS = cgsm_pkg::MaxStops;
    localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW = $clog2(MAX_STOPS + 1);
    localparam int PW = cgsm_pkg::PosW;
    localparam int NW = cgsm_pkg::ChW + PW; // numerator width
    localparam int DCW = $clog2(NW + 1);

    logic [PW-1:0] pos_reg [MAX_STOPS];
    logic [63:0]   col_reg [MAX_STOPS];
    logic [CW-1:0] cnt_reg;
    logic [2:0]    func_reg;
    logic [PW-1:0] key_reg;
    logic [3:0]    ridx_reg;
    logic [63:0]   cin_reg;
    logic          tbad_reg;
    logic [CW-1:0] idx_reg;
    logic [PW-1:0] plo_reg, phi_reg;
    logic [63:0]   clo_reg, chi_reg;
    logic [1:0]    mode_reg; // 0 copy lo, 1 blend
    logic [NW-1:0] num_reg [4];
    logic [NW-1:0] rem_reg [4];
    logic [NW-1:0] quo_reg [4];
    logic [PW-1:0] span_reg;
    logic [DCW-1:0] dcnt_reg;
    logic          dbusy_reg;
    logic [2:0]    status_reg;
    logic [63:0]   out_reg;

    logic [IW-1:0] ix, ixm1, lo_i, hi_i;
    logic [IW-1:0] wix;
    logic signed [17:0] ts;
    logic [PW-1:0] tclamp;
    logic          div_last;

    assign ix = idx_reg[IW-1:0];
    assign ixm1 = ix - 1'b1;

    always_comb begin
        ts = lookup_t_i;
        if (ts < 0) begin
            tclamp = '0;
        end else if (ts > $signed({1'b0, cgsm_pkg::OneQ16})) begin
            tclamp = cgsm_pkg::OneQ16;
        end else begin
            tclamp = ts[PW-1:0];
        end
    end

    assign div_last = dbusy_reg && (dcnt_reg == DCW'(NW));

    assign st.func = func_reg;
    assign st.t_bad = tbad_reg;
    assign st.full = (cnt_reg == CW'(MAX_STOPS));
    assign st.empty = (cnt_reg == '0);
    assign st.few = (cnt_reg < CW'(2));
    assign st.idx_bad = ({1'b0, ridx_reg} >= 5'(cnt_reg));
    assign st.scan_end = (idx_reg == cnt_reg);
    assign st.scan_hit = (pos_reg[ix] > key_reg);
    assign st.at_ins = (idx_reg == '0) || (pos_reg[ixm1] <= key_reg);
    // a copy leaves the divider idle, so it is done at once
    assign st.div_done = !dbusy_reg || div_last;

    assign wix = (func_reg == cgsm_pkg::FN_SET_LAST) ? IW'(cnt_reg - 1'b1) : '0;

    // bracket selection after the scan
    always_comb begin
        lo_i = '0;
        hi_i = '0;
        if (idx_reg == cnt_reg) begin
            if (key_reg > pos_reg[IW'(cnt_reg - 1'b1)]) begin
                lo_i = IW'(cnt_reg - 1'b1);
                hi_i = lo_i;
            end else begin
                lo_i = (key_reg == '0) ? '0 : IW'(cnt_reg - CW'(2));
                hi_i = lo_i + 1'b1;
                if (pos_reg[hi_i] != pos_reg[lo_i]) begin
                    lo_i = hi_i;
                end
                hi_i = lo_i;
            end
        end else if (idx_reg == '0) begin
            lo_i = '0;
            hi_i = '0;
        end else begin
            lo_i = ixm1;
            hi_i = ix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            dbusy_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.mul) begin
                dbusy_reg <= (mode_reg == 2'd1);
            end else if (!cmd.div_start) begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_i;
            key_reg <= (func_i == cgsm_pkg::FN_INSERT) ? stop_pos_i : tclamp;
            tbad_reg <= (stop_pos_i > cgsm_pkg::OneQ16);
            ridx_reg <= stop_index_i;
            cin_reg <= color_i;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.clr_color) begin
            out_reg <= '0;
        end
        if (cmd.scan_rst) begin
            idx_reg <= (func_reg == cgsm_pkg::FN_INSERT) ? '0 : '0;
        end else if (cmd.scan_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end else if (cmd.shift) begin
            pos_reg[ix] <= pos_reg[ixm1];
            col_reg[ix] <= col_reg[ixm1];
            idx_reg <= idx_reg - 1'b1;
        end
        // insert scans to the count then shifts down from it
        if (func_reg == cgsm_pkg::FN_INSERT && cmd.scan_inc == 1'b0 && st.scan_end
            && !cmd.shift && !cmd.wr_new && !cmd.scan_rst) begin
            idx_reg <= idx_reg;
        end
        if (cmd.wr_new) begin
            pos_reg[ix] <= key_reg;
            col_reg[ix] <= cin_reg;
        end
        if (cmd.wr_color) begin
            col_reg[wix] <= cin_reg;
        end
        if (cmd.rd_lo && !cmd.rd_hi) begin
            out_reg <= col_reg[ridx_reg[IW-1:0]];
        end
        if (cmd.rd_hi) begin
            plo_reg <= pos_reg[lo_i];
            phi_reg <= pos_reg[hi_i];
            clo_reg <= col_reg[lo_i];
            chi_reg <= col_reg[hi_i];
            mode_reg <= (lo_i != hi_i) ? 2'd1 : 2'd0;
        end
        if (cmd.mul) begin
            span_reg <= phi_reg - plo_reg;
            for (int c = 0; c < 4; c++) begin
                num_reg[c] <= NW'(clo_reg[c*16 +: 16]) * NW'(phi_reg - key_reg)
                            + NW'(chi_reg[c*16 +: 16]) * NW'(key_reg - plo_reg);
                rem_reg[c] <= '0;
                quo_reg[c] <= '0;
            end
            dcnt_reg <= '0;
            if (mode_reg != 2'd1) begin
                out_reg <= clo_reg;
            end
        end
        if (cmd.div_start && dbusy_reg) begin
            // restoring division, one quotient bit per channel a cycle
            for (int c = 0; c < 4; c++) begin
                logic [NW:0] tr;
                tr = {rem_reg[c], num_reg[c][NW-1]};
                if (tr >= (NW+1)'(span_reg)) begin
                    tr = tr - (NW+1)'(span_reg);
                    quo_reg[c] <= {quo_reg[c][NW-2:0], 1'b1};
                end else begin
                    quo_reg[c] <= {quo_reg[c][NW-2:0], 1'b0};
                end
                rem_reg[c] <= tr[NW-1:0];
                num_reg[c] <= {num_reg[c][NW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (div_last) begin
            for (int c = 0; c < 4; c++) begin
                out_reg[c*16 +: 16] <= quo_reg[c][15:0];
            end
        end
    end

    assign status_o = status_reg;
    assign color_o = out_reg;
    assign count_o = 5'(cnt_reg);
endmodule

/* bench/cgsm_checker.sv */
// checker for the color gradient stop map: predicts each result word and compares it
`timescale 1ns / 1ps
module cgsm_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic [4:0]  count;
    } grad_result_t;

    logic [cgsm_pkg::PosW-1:0] stop_at [cgsm_pkg::MaxStops];
    logic [cgsm_pkg::ColW-1:0] stop_color [cgsm_pkg::MaxStops];
    int unsigned     stops_held;
    grad_result_t    result_fifo [$];

    assign pending = result_fifo.size();

    // exact channel blend with truncation
    function automatic logic [15:0] mix(logic [15:0] a, logic [15:0] b,
                                        longint unsigned span, longint unsigned d);
        longint unsigned num;
        num = longint'(a) * (span - d) + longint'(b) * d;
        return 16'(num / span);
    endfunction

    function automatic grad_result_t eval_gradient(logic [2:0] fn, logic [103:0] w);
        grad_result_t r;
        logic signed [17:0] raw_t;
        int unsigned t, lo, hi, k, idx;
        logic [cgsm_pkg::ColW-1:0] col, ca, cb;
        longint unsigned span, d;
        logic [16:0] p;
        bit found;
        r = '0;
        raw_t = w[17:0];
        p = w[34:18];
        idx = w[38:35];
        col = w[102:39];
        found = 0;
        case (fn)
            cgsm_pkg::FN_LOOKUP: begin
                if (stops_held < 2) begin
                    r.status = cgsm_pkg::ST_FEW;
                end else begin
                    if (raw_t < 0) t = 0;
                    else if (raw_t > 65536) t = 65536;
                    else t = raw_t;
                    for (k = 0; k < stops_held && !found; k++) begin
                        if (stop_at[k] > t) begin
                            found = 1;
                            if (k == 0) begin
                                col = stop_color[0];
                            end else begin
                                ca = stop_color[k-1];
                                cb = stop_color[k];
                                span = stop_at[k] - stop_at[k-1];
                                d = t - stop_at[k-1];
                                col = {mix(ca[63:48], cb[63:48], span, d),
                                       mix(ca[47:32], cb[47:32], span, d),
                                       mix(ca[31:16], cb[31:16], span, d),
                                       mix(ca[15:0], cb[15:0], span, d)};
                            end
                        end
                    end
                    if (!found) begin
                        if (t > stop_at[stops_held-1]) begin
                            col = stop_color[stops_held-1];
                        end else begin
                            lo = (t == 0) ? 0 : stops_held - 2;
                            hi = lo + 1;
                            col = (stop_at[hi] == stop_at[lo]) ? stop_color[lo]
                                                               : stop_color[hi];
                        end
                    end
                    {r.alpha, r.blue, r.green, r.red} = col;
                end
            end
            cgsm_pkg::FN_INSERT: begin
                if (p > cgsm_pkg::OneQ16) begin
                    r.status = cgsm_pkg::ST_BADPOS;
                end else if (stops_held >= cgsm_pkg::MaxStops) begin
                    r.status = cgsm_pkg::ST_FULL;
                end else begin
                    k = 0;
                    while (k < stops_held && stop_at[k] <= p) k++;
                    for (lo = stops_held; lo > k; lo--) begin
                        stop_at[lo] = stop_at[lo-1];
                        stop_color[lo] = stop_color[lo-1];
                    end
                    stop_at[k] = p;
                    stop_color[k] = col;
                    stops_held++;
                end
            end
            cgsm_pkg::FN_SET_FIRST, cgsm_pkg::FN_SET_LAST: begin
                if (stops_held == 0) r.status = cgsm_pkg::ST_EMPTY;
                else if (fn == cgsm_pkg::FN_SET_LAST) stop_color[stops_held-1] = col;
                else stop_color[0] = col;
            end
            cgsm_pkg::FN_READ: begin
                if (idx >= stops_held) r.status = cgsm_pkg::ST_BADIDX;
                else {r.alpha, r.blue, r.green, r.red} = stop_color[idx];
            end
            default: ;
        endcase
        r.count = 5'(stops_held);
        return r;
    endfunction

    always @(posedge aclk) begin
        grad_result_t want, got;
        if (!aresetn) begin
            stops_held <= 0;
            fail_count <= 0;
            result_fifo.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                       m_tdata[63:48], m_tdata[68:64]};
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected word status %0d data %h", $time,
                             m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_fifo.pop_front();
                    if (got !== want || m_tdata[71:69] !== 3'b0) begin
                        $display("%0t: mismatch expected st %0d rgba %h %h %h %h n %0d",
                                 $time, want.status, want.red, want.green, want.blue,
                                 want.alpha, want.count);
                        $display("%0t:          actual   st %0d rgba %h %h %h %h n %0d",
                                 $time, got.status, got.red, got.green, got.blue,
                                 got.alpha, got.count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                result_fifo = {result_fifo, eval_gradient(s_tuser, s_tdata)};
        end
    end

endmodule

/* bench/testbench.sv */
// testbench top: drives gradient commands and gives the verdict
`timescale 1ns / 1ps
module testbench;

    localparam int WatchdogLimit = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [71:0]  m_tdata;
    logic [2:0]   m_tuser;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    bit           steady = 0;   // no idling on either side
    int           held = 0;     // insert count the stimulus tracks

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    color_gradient_stop_map_top dut (.*);

    cgsm_checker checker_i (.*);

    always @(posedge aclk) begin
        if (aresetn)
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit) begin
            $display("color_gradient_stop_map_top regression: fail");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] fn, logic signed [17:0] t, logic [16:0] p,
                             logic [3:0] idx, logic [63:0] col);
        while (!steady && $urandom_range(99) < 30) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= fn;
        s_tdata <= {1'b0, col, idx, p, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (fn == cgsm_pkg::FN_INSERT && p <= cgsm_pkg::OneQ16 && held < cgsm_pkg::MaxStops)
            held++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_color();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [16:0] rand_pos();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return cgsm_pkg::OneQ16;
            2: return 17'($urandom_range(8)) * 17'd8192;
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic random_op();
        int pick;
        logic [2:0] fn;
        pick = $urandom_range(99);
        if (pick < 40) fn = cgsm_pkg::FN_LOOKUP;
        else if (pick < 62) fn = cgsm_pkg::FN_INSERT;
        else if (pick < 72) fn = cgsm_pkg::FN_SET_FIRST;
        else if (pick < 82) fn = cgsm_pkg::FN_SET_LAST;
        else if (pick < 97) fn = cgsm_pkg::FN_READ;
        else fn = 3'($urandom_range(7, 5));
        send_word(fn,
                  ($urandom_range(9) == 0) ? 18'($urandom) : 18'($urandom_range(70000)),
                  ($urandom_range(15) == 0) ? 17'($urandom) : rand_pos(),
                  4'($urandom), rand_color());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // empty and single-stop table cases
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd100, '0, '0, '0);
        send_word(cgsm_pkg::FN_SET_FIRST, '0, '0, '0, {64{1'b1}});
        send_word(cgsm_pkg::FN_SET_LAST, '0, '0, '0, {64{1'b1}});
        send_word(cgsm_pkg::FN_READ, '0, '0, 4'd0, '0);
        send_word(cgsm_pkg::FN_INSERT, '0, 17'd65537, '0, '1);
        send_word(cgsm_pkg::FN_INSERT, '0, 17'h1ffff, '0, '1);
        send_word(cgsm_pkg::FN_INSERT, '0, 17'd32768, '0, 64'h0123_4567_89ab_cdef);
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd32768, '0, '0, '0);
        send_word(cgsm_pkg::FN_INSERT, '0, 17'd32768, '0, 64'hffff_0000_ffff_0000);
        // zero-width span at the last position
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd32768, '0, '0, '0);
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd100, '0, '0, '0);
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd60000, '0, '0, '0);
        send_word(cgsm_pkg::FN_INSERT, '0, 17'd0, '0, '0);
        send_word(cgsm_pkg::FN_INSERT, '0, cgsm_pkg::OneQ16, '0, '1);
        send_word(cgsm_pkg::FN_LOOKUP, 18'h20000, '0, '0, '0);
        send_word(cgsm_pkg::FN_LOOKUP, 18'h1ffff, '0, '0, '0);
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd65536, '0, '0, '0);
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd16385, '0, '0, '0);
        send_word(cgsm_pkg::FN_SET_FIRST, '0, '0, '0, 64'h5555_aaaa_5555_aaaa);
        send_word(cgsm_pkg::FN_SET_LAST, '0, '0, '0, 64'haaaa_5555_aaaa_5555);
        send_word(cgsm_pkg::FN_READ, '0, '0, 4'd3, '0);
        send_word(cgsm_pkg::FN_READ, '0, '0, 4'd15, '0);
        send_word(3'd7, '1, '1, '1, '1);
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd49000, '0, '0, '0);
        while (held < cgsm_pkg::MaxStops)
            send_word(cgsm_pkg::FN_INSERT, '0, rand_pos(), '0, rand_color());
        send_word(cgsm_pkg::FN_INSERT, '0, 17'd1000, '0, '1);
        send_word(cgsm_pkg::FN_LOOKUP, 18'sd0, '0, '0, '0);
        // sender holds off until the block drains
        drain();
        // random phase on the full table
        for (int n = 0; n < 910; n++) begin
            steady = (n >= 300 && n < 400);
            if (held == cgsm_pkg::MaxStops && $urandom_range(3) == 0) begin
                drain();
            end
            random_op();
        end
        steady = 1;
        drain();
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("color_gradient_stop_map_top regression: pass");
        else
            $display("color_gradient_stop_map_top regression: fail");
        $finish;
    end

endmodule

/* color_gradient_stop_map_top.f */
hw/rtl/cgsm_pkg.sv
hw/rtl/cgsm_ctrl.sv
hw/rtl/cgsm_dpath.sv
hw/rtl/color_gradient_stop_map_top.sv
bench/cgsm_checker.sv
bench/testbench.sv
